@@ hw/rtl/tts_pkg.sv @@
// Shared types, constants and helper functions for the two-button time setter.
// Used by every module of the block; depends on nothing.
package tts_pkg;

    localparam int HOLD_W  = 12;
    localparam int BLINK_W = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int TDATA_W = 24;

    localparam logic [HOLD_W-1:0]  HOLD_MAX          = '1;
    localparam logic [HOLD_W-1:0]  LONG_PRESS_RESET  = 12'd200;
    localparam logic [BLINK_W-1:0] BLINK_SHOW_RESET  = 16'd1000;
    localparam logic [BLINK_W-1:0] BLINK_PERIOD_RESET = 16'd2000;
    localparam logic [5:0]         MINSEC_MAX        = 6'd59;
    localparam logic [4:0]         HOUR_MAX          = 5'd23;

    localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [1:0] REG_BLINK_SHOW   = 2'd1;
    localparam logic [1:0] REG_BLINK_PERIOD = 2'd2;

    localparam logic [1:0] KEY_ADVANCE = 2'd1;
    localparam logic [1:0] KEY_RETREAT = 2'd2;

    localparam logic [1:0] FIELD_SEC  = 2'd0;
    localparam logic [1:0] FIELD_MIN  = 2'd1;
    localparam logic [1:0] FIELD_HOUR = 2'd2;
    localparam logic [1:0] FIELD_NONE = 2'd3;

    localparam logic [1:0] DISP_FULL    = 2'd0;
    localparam logic [1:0] DISP_BLANKED = 2'd1;
    localparam logic [1:0] DISP_NONE    = 2'd2;

    typedef struct packed {
        logic [HOLD_W-1:0]  long_press_ticks;
        logic [BLINK_W-1:0] blink_show_ticks;
        logic [BLINK_W-1:0] blink_period_ticks;
    } t_cfg;

    typedef struct packed {
        logic [4:0]         hours;
        logic [5:0]         minutes;
        logic [5:0]         seconds;
        logic [1:0]         field_select;
        logic [HOLD_W-1:0]  advance_hold_count;
        logic [HOLD_W-1:0]  retreat_hold_count;
        logic [BLINK_W-1:0] blink_count;
    } t_state;

    typedef struct packed {
        logic [5:0] hour_bcd;
        logic [6:0] minute_bcd;
        logic [6:0] second_bcd;
        logic [1:0] edit_field;
        logic [1:0] display_state;
        logic       committed;
    } t_result;

    // Two BCD digits of a value below 64.
    function automatic logic [6:0] to_bcd(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] rest;
        if (v >= 6'd60) begin
            tens = 3'd6;
        end else if (v >= 6'd50) begin
            tens = 3'd5;
        end else if (v >= 6'd40) begin
            tens = 3'd4;
        end else if (v >= 6'd30) begin
            tens = 3'd3;
        end else if (v >= 6'd20) begin
            tens = 3'd2;
        end else if (v >= 6'd10) begin
            tens = 3'd1;
        end else begin
            tens = 3'd0;
        end
        rest = v - 6'({3'd0, tens} * 6'd10);
        return {tens, rest[3:0]};
    endfunction

endpackage

@@ hw/rtl/tts_cfg_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on tts_pkg for register indexes, widths and reset values.
module tts_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tts_pkg::ADDR_W-1:0] paddr,
    input  logic [tts_pkg::DATA_W-1:0] pwdata,
    output logic [tts_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output tts_pkg::t_cfg             o_cfg
);
    import tts_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks   <= LONG_PRESS_RESET;
            r_cfg.blink_show_ticks   <= BLINK_SHOW_RESET;
            r_cfg.blink_period_ticks <= BLINK_PERIOD_RESET;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_LONG_PRESS:   r_cfg.long_press_ticks   <= pwdata[HOLD_W-1:0];
                REG_BLINK_SHOW:   r_cfg.blink_show_ticks   <= pwdata[BLINK_W-1:0];
                REG_BLINK_PERIOD: r_cfg.blink_period_ticks <= pwdata[BLINK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LONG_PRESS:   prdata = {{(DATA_W-HOLD_W){1'b0}}, r_cfg.long_press_ticks};
            REG_BLINK_SHOW:   prdata = {{(DATA_W-BLINK_W){1'b0}}, r_cfg.blink_show_ticks};
            REG_BLINK_PERIOD: prdata = {{(DATA_W-BLINK_W){1'b0}}, r_cfg.blink_period_ticks};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/tts_step.sv @@
// Next-state and result logic for one key sample.
// Depends on tts_pkg for the state, configuration and result types.
module tts_step (
    input  logic [1:0]          i_key,
    input  tts_pkg::t_state     i_state,
    input  tts_pkg::t_cfg       i_cfg,
    output tts_pkg::t_state     o_state,
    output tts_pkg::t_result    o_result
);
    import tts_pkg::*;

    t_state s;
    logic   adv_fire;
    logic   ret_fire;
    logic   adv_short;
    logic   ret_short;
    logic [BLINK_W-1:0] blink_inc;
    logic [1:0] disp;
    logic [6:0] commit_hour;
    logic [6:0] shown_hour;

    assign adv_fire  = (i_state.advance_hold_count == i_cfg.long_press_ticks) &&
                       (i_state.advance_hold_count != HOLD_MAX);
    assign ret_fire  = (i_state.retreat_hold_count == i_cfg.long_press_ticks) &&
                       (i_state.retreat_hold_count != HOLD_MAX);
    assign adv_short = (i_state.advance_hold_count != '0) &&
                       (i_state.advance_hold_count < i_cfg.long_press_ticks);
    assign ret_short = (i_state.retreat_hold_count != '0) &&
                       (i_state.retreat_hold_count < i_cfg.long_press_ticks);
    assign blink_inc = i_state.blink_count + 1'b1;

    always_comb begin
        s    = i_state;
        disp = DISP_FULL;

        // Button one: count the hold and step the field at a long hold, or act on its release.
        if (i_key == KEY_ADVANCE) begin
            if (s.advance_hold_count != HOLD_MAX) begin
                s.advance_hold_count = s.advance_hold_count + 1'b1;
            end
            if (adv_fire && s.field_select != FIELD_NONE) begin
                s.field_select = s.field_select + 1'b1;
            end
        end else begin
            if (adv_short) begin
                case (s.field_select)
                    FIELD_SEC:  if (s.seconds < MINSEC_MAX) s.seconds = s.seconds + 1'b1;
                    FIELD_MIN:  if (s.minutes < MINSEC_MAX) s.minutes = s.minutes + 1'b1;
                    FIELD_HOUR: if (s.hours < HOUR_MAX) s.hours = s.hours + 1'b1;
                    default: ;
                endcase
            end
            s.advance_hold_count = '0;
        end

        // Button two: the release of a short press lowers the field; a long hold is a commit.
        if (i_key == KEY_RETREAT) begin
            if (s.retreat_hold_count != HOLD_MAX) begin
                s.retreat_hold_count = s.retreat_hold_count + 1'b1;
            end
        end else begin
            if (ret_short) begin
                case (s.field_select)
                    FIELD_SEC:  if (s.seconds != '0) s.seconds = s.seconds - 1'b1;
                    FIELD_MIN:  if (s.minutes != '0) s.minutes = s.minutes - 1'b1;
                    FIELD_HOUR: if (s.hours != '0) s.hours = s.hours - 1'b1;
                    default: ;
                endcase
            end
            s.retreat_hold_count = '0;
        end

        if (s.field_select != FIELD_NONE) begin
            if (i_state.blink_count <= i_cfg.blink_show_ticks) begin
                s.blink_count = blink_inc;
                disp          = DISP_FULL;
            end else if (blink_inc <= i_cfg.blink_period_ticks) begin
                s.blink_count = blink_inc;
                disp          = DISP_BLANKED;
            end else begin
                s.blink_count = '0;
                disp          = DISP_NONE;
            end
        end

        commit_hour = to_bcd({1'b0, s.hours});
        shown_hour  = to_bcd({1'b0, i_state.hours});

        if (i_key == KEY_RETREAT && ret_fire) begin
            o_result.hour_bcd      = commit_hour[5:0];
            o_result.minute_bcd    = to_bcd(s.minutes);
            o_result.second_bcd    = to_bcd(s.seconds);
            o_result.edit_field    = FIELD_SEC;
            o_result.display_state = DISP_NONE;
            o_result.committed     = 1'b1;
            o_state                = '0;
        end else begin
            o_result.hour_bcd      = shown_hour[5:0];
            o_result.minute_bcd    = to_bcd(i_state.minutes);
            o_result.second_bcd    = to_bcd(i_state.seconds);
            o_result.edit_field    = s.field_select;
            o_result.display_state = disp;
            o_result.committed     = 1'b0;
            o_state                = s;
        end
    end

endmodule

@@ hw/rtl/two_button_time_setter_core.sv @@
// Top level of the two-button time setter: stream ports, input and result
// registers, edit state. Depends on tts_pkg, tts_cfg_regs and tts_step.
//
// One key sample is taken per word and yields exactly one result word. A word
// enters the input register, is worked through the next-state logic and lands
// in the result register, so a new word is accepted every cycle while the
// result side takes each result word, and the result word is held in the
// result register until it is taken. The input register lets a new word be
// taken while a finished result still waits in the result register.
// Registers should be written only while no word is in flight.
module two_button_time_setter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [1:0] key_level, [7:2] zero
    input  logic [7:0]                  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [5:0] hour_bcd, [12:6] minute_bcd, [19:13] second_bcd,
    // [21:20] edit_field, [23:22] display_state
    output logic [tts_pkg::TDATA_W-1:0] m_axis_tdata,
    // [0] committed
    output logic                        m_axis_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tts_pkg::ADDR_W-1:0]  paddr,
    input  logic [tts_pkg::DATA_W-1:0]  pwdata,
    output logic [tts_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import tts_pkg::*;

    t_cfg    w_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result w_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic [1:0] r_key;
    logic    w_advance;

    tts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tts_step u_step (
        .i_key    (r_key),
        .i_state  (r_state),
        .i_cfg    (w_cfg),
        .o_state  (n_state),
        .o_result (w_result)
    );

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_key <= s_axis_tdata[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_result.display_state, r_result.edit_field,
                            r_result.second_bcd, r_result.minute_bcd, r_result.hour_bcd};
    assign m_axis_tuser  = r_result.committed;

    a_commit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.committed) |->
        (r_result.edit_field == FIELD_SEC && r_result.display_state == DISP_NONE))
        else $error("commit word with wrong edit field or display state");

    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_result.committed) |=> (r_state == '0))
        else $error("state not cleared after a commit");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.hours <= HOUR_MAX && r_state.minutes <= MINSEC_MAX &&
         r_state.seconds <= MINSEC_MAX))
        else $error("time field out of range");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state))
        else $error("state changed without a word");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for two_button_time_setter_core: random key streams, stalls on both
// stream sides and several register settings, with every result word checked in order.
// Depends on tts_pkg and the two_button_time_setter_core RTL.
module testbench;
    import tts_pkg::*;

    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_BOTH = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [1:0] key_level, [7:2] zero
    logic [7:0]          s_axis_tdata = 8'd0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [5:0] hour_bcd, [12:6] minute_bcd, [19:13] second_bcd,
    // [21:20] edit_field, [23:22] display_state
    logic [TDATA_W-1:0]  m_axis_tdata;
    // [0] committed
    logic                m_axis_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    two_button_time_setter_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies and edit state of the predicted setter.
    logic [HOLD_W-1:0]  lp_ticks = LONG_PRESS_RESET;
    logic [BLINK_W-1:0] show_ticks = BLINK_SHOW_RESET;
    logic [BLINK_W-1:0] period_ticks = BLINK_PERIOD_RESET;
    logic [4:0]         hrs = '0;
    logic [5:0]         mins = '0;
    logic [5:0]         secs = '0;
    logic [1:0]         sel = '0;
    logic [HOLD_W-1:0]  adv_hold = '0;
    logic [HOLD_W-1:0]  ret_hold = '0;
    logic [BLINK_W-1:0] blink_cnt = '0;

    logic [1:0] key_queue[$];
    t_result    expected_readouts[$];
    t_result    seen_word;
    logic       word_taken = 1'b0;
    int         keys_queued = 0;
    int         keys_sent = 0;
    int         results_checked = 0;
    int         failures = 0;
    int         commits_seen = 0;
    int         blanked_seen = 0;
    int         dark_seen = 0;
    int         cycle_count = 0;

    function automatic logic [7:0] as_bcd(input int v);
        return 8'((v / 10) * 16 + v % 10);
    endfunction

    function automatic void nudge_field(input bit up);
        case (sel)
            FIELD_SEC: begin
                if (up && secs < MINSEC_MAX) secs++;
                else if (!up && secs != 0) secs--;
            end
            FIELD_MIN: begin
                if (up && mins < MINSEC_MAX) mins++;
                else if (!up && mins != 0) mins--;
            end
            FIELD_HOUR: begin
                if (up && hrs < HOUR_MAX) hrs++;
                else if (!up && hrs != 0) hrs--;
            end
            default: ;
        endcase
    endfunction

    // One key sample: edits the predicted state and returns the result word it causes.
    function automatic t_result setter_tick(input logic [1:0] key);
        t_result            r;
        logic               fired;
        logic [BLINK_W-1:0] prev;
        r.hour_bcd   = 6'(as_bcd(hrs));
        r.minute_bcd = 7'(as_bcd(mins));
        r.second_bcd = 7'(as_bcd(secs));
        r.committed  = 1'b0;
        if (key == KEY_ADVANCE) begin
            fired = (adv_hold == lp_ticks) && (adv_hold != HOLD_MAX);
            if (adv_hold != HOLD_MAX) adv_hold++;
            if (fired && sel != FIELD_NONE) sel++;
        end else begin
            if (adv_hold != 0 && adv_hold < lp_ticks) nudge_field(1'b1);
            adv_hold = '0;
        end
        if (key == KEY_RETREAT) begin
            fired = (ret_hold == lp_ticks) && (ret_hold != HOLD_MAX);
            if (ret_hold != HOLD_MAX) ret_hold++;
            if (fired) begin
                r.hour_bcd      = 6'(as_bcd(hrs));
                r.minute_bcd    = 7'(as_bcd(mins));
                r.second_bcd    = 7'(as_bcd(secs));
                r.edit_field    = FIELD_SEC;
                r.display_state = DISP_NONE;
                r.committed     = 1'b1;
                hrs = '0; mins = '0; secs = '0; sel = '0;
                adv_hold = '0; ret_hold = '0; blink_cnt = '0;
                return r;
            end
        end else begin
            if (ret_hold != 0 && ret_hold < lp_ticks) nudge_field(1'b0);
            ret_hold = '0;
        end
        if (sel != FIELD_NONE) begin
            prev = blink_cnt;
            blink_cnt = prev + 16'd1;
            if (prev <= show_ticks) begin
                r.display_state = DISP_FULL;
            end else if (blink_cnt <= period_ticks) begin
                r.display_state = DISP_BLANKED;
            end else begin
                blink_cnt = '0;
                r.display_state = DISP_NONE;
            end
        end else begin
            r.display_state = DISP_FULL;
        end
        r.edit_field = sel;
        return r;
    endfunction

    // Result side first, so that a spurious word cannot consume a fresh expectation.
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_word.hour_bcd      = m_axis_tdata[5:0];
            seen_word.minute_bcd    = m_axis_tdata[12:6];
            seen_word.second_bcd    = m_axis_tdata[19:13];
            seen_word.edit_field    = m_axis_tdata[21:20];
            seen_word.display_state = m_axis_tdata[23:22];
            seen_word.committed     = m_axis_tuser;
            if (expected_readouts.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("Result word arrived with none expected: %h user %b",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                if (seen_word !== expected_readouts[0]) begin
                    failures++;
                    if (failures <= 10)
                        $display({"Result %0d differs: expected %h:%h:%h field %0d ",
                                  "display %0d commit %b, got %h:%h:%h field %0d ",
                                  "display %0d commit %b"}, results_checked,
                                 expected_readouts[0].hour_bcd,
                                 expected_readouts[0].minute_bcd,
                                 expected_readouts[0].second_bcd,
                                 expected_readouts[0].edit_field,
                                 expected_readouts[0].display_state,
                                 expected_readouts[0].committed,
                                 seen_word.hour_bcd, seen_word.minute_bcd,
                                 seen_word.second_bcd, seen_word.edit_field,
                                 seen_word.display_state, seen_word.committed);
                end
                if (expected_readouts[0].committed) commits_seen++;
                if (expected_readouts[0].display_state == DISP_BLANKED) blanked_seen++;
                if (expected_readouts[0].display_state == DISP_NONE) dark_seen++;
                void'(expected_readouts.pop_front());
            end
            results_checked++;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_readouts.push_back(setter_tick(s_axis_tdata[1:0]));
            keys_sent++;
        end
    end

    // Key sender: bursts of random length, random gaps, and now and then a full drain.
    int burst_left = 0;
    int gap_left = 0;
    int bursts_done = 0;
    bit draining = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (burst_left == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(draining && expected_readouts.size() > 0)) begin
                    draining = 1'b0;
                    burst_left = $urandom_range(1, 16);
                end
            end
            if (burst_left > 0 && key_queue.size() > 0) begin
                s_axis_tdata  <= {6'd0, key_queue.pop_front()};
                s_axis_tvalid <= 1'b1;
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
                    bursts_done++;
                    if (bursts_done % 20 == 0) draining = 1'b1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: its own stall pattern, in one of four modes picked at random.
    int stall_mode = 0;
    int stall_left = 0;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 128);
        end
        stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (stall_left % 3 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 20 * keys_queued + 50000) begin
            $display("Run stopped after %0d cycles with %0d words still expected.",
                     cycle_count, expected_readouts.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic hold(input logic [1:0] key, input int n);
        repeat (n) key_queue.push_back(key);
        keys_queued += n;
    endtask

    function automatic int short_hold();
        int longest;
        longest = (lp_ticks > 1) ? int'(lp_ticks) - 1 : 1;
        if (longest <= 16 && $urandom_range(0, 3) == 0) return longest;
        return $urandom_range(1, (longest < 6) ? longest : 6);
    endfunction

    function automatic logic [1:0] idle_key();
        return ($urandom_range(0, 3) == 0) ? KEY_BOTH : KEY_NONE;
    endfunction

    task automatic wait_quiet();
        while (key_queue.size() != 0 || s_axis_tvalid || expected_readouts.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_LONG_PRESS: lp_ticks = value[HOLD_W-1:0];
            REG_BLINK_SHOW: show_ticks = value;
            default: period_ticks = value;
        endcase
    endtask

    task automatic apply_settings(input int lp, input int show, input int period);
        wait_quiet();
        reg_write(REG_LONG_PRESS, 16'(lp));
        reg_write(REG_BLINK_SHOW, 16'(show));
        reg_write(REG_BLINK_PERIOD, 16'(period));
    endtask

    // Mostly well-formed presses with random content, the rest loose key noise.
    task automatic queue_random_gestures(input int n);
        int         target;
        int         pick;
        int         reps;
        logic [1:0] btn;
        target = keys_queued + n;
        while (keys_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                btn  = ($urandom_range(0, 3) == 0) ? KEY_RETREAT : KEY_ADVANCE;
                reps = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 20)
                                                   : $urandom_range(1, 10);
                repeat (reps) begin
                    hold(btn, short_hold());
                    hold(idle_key(), $urandom_range(1, 2));
                end
            end else if (pick < 65 && lp_ticks <= 16) begin
                hold(KEY_ADVANCE, int'(lp_ticks) + 1 + $urandom_range(0, 2));
                hold(idle_key(), 1);
            end else if (pick < 72 && lp_ticks <= 16) begin
                hold(KEY_RETREAT, int'(lp_ticks) + 1 + $urandom_range(0, 2));
                hold(idle_key(), 1);
            end else if (pick < 82) begin
                hold(KEY_ADVANCE, short_hold());
                if (lp_ticks <= 16 && $urandom_range(0, 2) == 0)
                    hold(KEY_RETREAT, int'(lp_ticks) + 1);
                else
                    hold(KEY_RETREAT, short_hold());
                if ($urandom_range(0, 1) == 0) hold(KEY_ADVANCE, short_hold());
                hold(idle_key(), 1);
            end else begin
                repeat ($urandom_range(1, 8)) hold(2'($urandom_range(0, 3)), 1);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: decrement at zero, release by both keys, then short presses.
        hold(KEY_RETREAT, 1);
        hold(KEY_NONE, 1);
        hold(KEY_ADVANCE, 3);
        hold(KEY_BOTH, 1);
        queue_random_gestures(80);

        apply_settings(3, 0, 1);
        hold(KEY_RETREAT, 1);
        hold(KEY_NONE, 1);
        hold(KEY_ADVANCE, 2);
        hold(KEY_BOTH, 1);
        hold(KEY_ADVANCE, 1);
        hold(KEY_RETREAT, 1);
        hold(KEY_NONE, 1);
        repeat (3) begin
            hold(KEY_ADVANCE, 4);
            hold(KEY_NONE, 1);
        end
        hold(KEY_ADVANCE, 5);
        hold(KEY_NONE, 1);
        hold(KEY_ADVANCE, 1);
        hold(KEY_ADVANCE, 1);
        hold(KEY_RETREAT, 4);
        queue_random_gestures(100);

        apply_settings(1, 9, 5);
        queue_random_gestures(100);

        // A zero threshold fires on the first held tick.
        apply_settings(0, 2, 4);
        hold(KEY_ADVANCE, 1);
        hold(KEY_NONE, 1);
        hold(KEY_RETREAT, 1);
        queue_random_gestures(40);

        apply_settings(6, 20, 40);
        queue_random_gestures(140);
        hold(KEY_RETREAT, 7);
        hold(KEY_NONE, 1);

        // Top settings: long holds far below the threshold are still short presses.
        apply_settings(4094, 65533, 65534);
        hold(KEY_ADVANCE, 20);
        hold(KEY_NONE, 1);
        hold(KEY_RETREAT, 20);
        hold(KEY_BOTH, 1);
        hold(KEY_NONE, 10);

        // A threshold at the counter top never fires.
        apply_settings(4095, 65533, 65534);
        hold(KEY_RETREAT, 20);
        hold(KEY_NONE, 1);
        hold(KEY_ADVANCE, 20);
        hold(KEY_BOTH, 1);
        queue_random_gestures(30);

        apply_settings(2, 3, 7);
        queue_random_gestures(70);

        wait_quiet();
        failures += expected_readouts.size();
        $display("Checked %0d result words for %0d key words over eight register settings.",
                 results_checked, keys_sent);
        $display("Seen %0d commits, %0d blanked and %0d no-refresh words; %0d failures.",
                 commits_seen, blanked_seen, dark_seen, failures);
        if (failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tts_pkg.sv
hw/rtl/tts_cfg_regs.sv
hw/rtl/tts_step.sv
hw/rtl/two_button_time_setter_core.sv
bench/testbench.sv
